### hdl/kpsum_pkg.sv
package kpsum_pkg;

  localparam int RANK_W    = 11;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int REG_RANK  = 0;

  localparam logic [RANK_W-1:0] RANK_RESET = 11'd1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_CHECK,
    S_RD,
    S_VIS,
    S_INS,
    S_NEXT,
    S_POP,
    S_EMIT,
    S_WIPE
  } state_t;

  typedef enum logic [1:0] {
    PH_UP,
    PH_LEFT,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    PQ_NOP,
    PQ_INS,
    PQ_POP,
    PQ_CLR
  } pq_op_t;

endpackage

### hdl/kpsum_in_if.sv
interface kpsum_in_if #(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] a_element;
  logic signed [VALUE_BITS-1:0] b_element;
  logic                         last_element;

  modport source (output valid, a_element, b_element, last_element, input ready);
  modport sink   (input valid, a_element, b_element, last_element, output ready);
endinterface

### hdl/kpsum_out_if.sv
interface kpsum_out_if #(
  parameter int VALUE_BITS = 32
);
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_BITS:0] kth_sum;
  logic                       status;

  modport source (output valid, kth_sum, status, input ready);
  modport sink   (input valid, kth_sum, status, output ready);
endinterface

### hdl/kpsum_cell.sv
module kpsum_cell #(
  parameter int KW = 49
) (
  input  logic              clk,
  input  logic              rst_n,
  input  kpsum_pkg::pq_op_t op,
  input  logic [KW-1:0]     new_key,
  input  logic              up_valid,
  input  logic [KW-1:0]     up_key,
  input  logic              up_beat,
  input  logic              dn_valid,
  input  logic [KW-1:0]     dn_key,
  output logic              valid,
  output logic [KW-1:0]     key,
  output logic              beat
);

  logic          valid_r, valid_nxt;
  logic [KW-1:0] key_r, key_nxt;

  // new entry ranks above this one (empty slots rank lowest)
  assign beat  = !valid_r || (new_key > key_r);
  assign valid = valid_r;
  assign key   = key_r;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    case (op)
      kpsum_pkg::PQ_INS: begin
        if (up_beat) begin
          valid_nxt = up_valid;
          key_nxt   = up_key;
        end else if (beat) begin
          valid_nxt = 1'b1;
          key_nxt   = new_key;
        end
      end
      kpsum_pkg::PQ_POP: begin
        valid_nxt = dn_valid;
        key_nxt   = dn_key;
      end
      kpsum_pkg::PQ_CLR: valid_nxt = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

### hdl/kpsum_queue.sv
module kpsum_queue #(
  parameter int DEPTH = 1024,
  parameter int KW    = 49
) (
  input  logic              clk,
  input  logic              rst_n,
  input  kpsum_pkg::pq_op_t op,
  input  logic [KW-1:0]     new_key,
  output logic              head_valid,
  output logic [KW-1:0]     head_key
);

  // link g is the output of cell g-1; the ends are tied off empty
  logic          lv [0:DEPTH+1];
  logic [KW-1:0] lk [0:DEPTH+1];
  logic          lb [0:DEPTH];

  assign lv[0]       = 1'b0;
  assign lk[0]       = '0;
  assign lb[0]       = 1'b0;
  assign lv[DEPTH+1] = 1'b0;
  assign lk[DEPTH+1] = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    kpsum_cell #(.KW(KW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .op       (op),
      .new_key  (new_key),
      .up_valid (lv[g]),
      .up_key   (lk[g]),
      .up_beat  (lb[g]),
      .dn_valid (lv[g+2]),
      .dn_key   (lk[g+2]),
      .valid    (lv[g+1]),
      .key      (lk[g+1]),
      .beat     (lb[g+1])
    );
  end

  assign head_valid = lv[1];
  assign head_key   = lk[1];

endmodule

### hdl/kth_largest_pair_sum.sv
// loading: one pair a cycle; the final pair starts a selection, no items taken meanwhile
// selection: each pop costs a queue shift and sequencing steps, plus up to two pushes
//   (visited-map read, mark, sorted insert)
// afterwards the visited entries of the job are wiped, one a cycle
// reset is synchronous; afterwards a sweep clears every entry of the visited map
//   before the first item is taken
module kth_largest_pair_sum #(
  parameter int MAX_N      = 256,
  parameter int MAX_K      = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  kpsum_in_if.sink                        in_ch,
  kpsum_out_if.source                     out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kpsum_pkg::APB_AW-1:0]    paddr,
  input  logic [kpsum_pkg::APB_DW-1:0]    pwdata,
  output logic [kpsum_pkg::APB_DW-1:0]    prdata,
  output logic                            pready
);

  localparam int VB    = VALUE_BITS;
  localparam int SW    = VB + 1;
  localparam int IW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int CW    = $clog2(MAX_N + 1);
  localparam int PW    = 2 * CW;
  localparam int RW    = kpsum_pkg::RANK_W;
  localparam int CMPW  = (PW > RW) ? PW : RW;
  localparam int VAW   = 2 * IW;
  localparam int VD    = 2 ** VAW;
  localparam int KW    = SW + VAW;
  localparam int LOGD  = 2 * MAX_K + 1;
  localparam int LAW   = $clog2(LOGD);
  localparam int LCW   = $clog2(LOGD + 1);

  kpsum_pkg::state_t state_r, state_nxt;
  kpsum_pkg::phase_t phase_r;
  kpsum_pkg::pq_op_t q_op;

  logic [RW-1:0]  rank_r;
  logic [RW-1:0]  pops_r;
  logic [CW-1:0]  cnt_r;
  logic [CW-1:0]  n_r;
  logic [CW-1:0]  n_m1;
  logic [PW-1:0]  pairs;
  logic           bad_rank;
  logic           err_r;
  logic [IW-1:0]  tgt_i_r, tgt_j_r;
  logic [IW-1:0]  pop_i_r, pop_j_r;
  logic signed [VB-1:0] a_q, b_q;
  logic           vis_q;
  logic [SW-1:0]  sum_r, ans_r;
  logic [LCW-1:0] log_cnt_r;
  logic [LCW-1:0] log_m1;
  logic [VAW-1:0] log_q;
  logic           wipe_pend_r;
  logic [VAW-1:0] clr_addr_r;
  logic           out_valid_r;
  logic [SW-1:0]  out_sum_r;
  logic           out_status_r;

  logic           in_take, in_full, cfg_wr, emit_go;
  logic [KW-1:0]  new_key, head_key;
  logic           head_valid;

  logic [VB-1:0]  a_mem   [0:MAX_N-1];
  logic [VB-1:0]  b_mem   [0:MAX_N-1];
  logic           vis_mem [0:VD-1];
  logic [VAW-1:0] log_mem [0:LOGD-1];

  assign in_take = in_ch.valid && in_ch.ready;
  assign in_full = (cnt_r >= CW'(MAX_N));
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign emit_go = !out_valid_r || out_ch.ready;
  assign n_m1    = n_r - CW'(1);
  assign log_m1  = log_cnt_r - LCW'(1);
  assign pairs   = PW'(n_r) * PW'(n_r);
  assign bad_rank = (rank_r == '0) || (CMPW'(rank_r) > CMPW'(pairs)) ||
                    (32'(rank_r) > 32'(MAX_K));
  assign new_key = {~sum_r[SW-1], sum_r[SW-2:0], tgt_i_r, tgt_j_r};

  assign pready = 1'b1;
  assign prdata = (paddr[kpsum_pkg::APB_AW-1:2] == (kpsum_pkg::APB_AW-2)'(kpsum_pkg::REG_RANK))
                  ? kpsum_pkg::APB_DW'(rank_r) : '0;

  assign out_ch.valid   = out_valid_r;
  assign out_ch.kth_sum = out_sum_r;
  assign out_ch.status  = out_status_r;

  kpsum_queue #(.DEPTH(MAX_K), .KW(KW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (q_op),
    .new_key    (new_key),
    .head_valid (head_valid),
    .head_key   (head_key)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kpsum_pkg::S_CLR:   if (&clr_addr_r) state_nxt = kpsum_pkg::S_IDLE;
      kpsum_pkg::S_IDLE:  if (in_take && in_ch.last_element) state_nxt = kpsum_pkg::S_CHECK;
      kpsum_pkg::S_CHECK: state_nxt = bad_rank ? kpsum_pkg::S_EMIT : kpsum_pkg::S_RD;
      kpsum_pkg::S_RD:    state_nxt = kpsum_pkg::S_VIS;
      kpsum_pkg::S_VIS:   state_nxt = vis_q ? kpsum_pkg::S_NEXT : kpsum_pkg::S_INS;
      kpsum_pkg::S_INS:   state_nxt = kpsum_pkg::S_NEXT;
      kpsum_pkg::S_NEXT: begin
        case (phase_r)
          kpsum_pkg::PH_UP:   if (pop_i_r != '0) state_nxt = kpsum_pkg::S_RD;
          kpsum_pkg::PH_LEFT: if (pop_j_r != '0) state_nxt = kpsum_pkg::S_RD;
          default: state_nxt = (pops_r == '0) ? kpsum_pkg::S_EMIT : kpsum_pkg::S_POP;
        endcase
      end
      kpsum_pkg::S_POP:   state_nxt = kpsum_pkg::S_NEXT;
      kpsum_pkg::S_EMIT:  if (emit_go) state_nxt = kpsum_pkg::S_WIPE;
      kpsum_pkg::S_WIPE:  if (log_cnt_r == '0) state_nxt = kpsum_pkg::S_IDLE;
      default:            state_nxt = kpsum_pkg::S_CLR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready = 1'b0;
    q_op        = kpsum_pkg::PQ_NOP;
    case (state_r)
      kpsum_pkg::S_IDLE:  in_ch.ready = 1'b1;
      kpsum_pkg::S_CHECK: q_op = kpsum_pkg::PQ_CLR;
      kpsum_pkg::S_INS:   q_op = kpsum_pkg::PQ_INS;
      kpsum_pkg::S_POP:   q_op = head_valid ? kpsum_pkg::PQ_POP : kpsum_pkg::PQ_NOP;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kpsum_pkg::S_CLR;
      phase_r     <= kpsum_pkg::PH_DONE;
      rank_r      <= kpsum_pkg::RANK_RESET;
      pops_r      <= '0;
      cnt_r       <= '0;
      log_cnt_r   <= '0;
      wipe_pend_r <= 1'b0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wipe_pend_r <= (state_r == kpsum_pkg::S_WIPE) && (log_cnt_r != '0);
      if (cfg_wr && paddr[kpsum_pkg::APB_AW-1:2] ==
          (kpsum_pkg::APB_AW-2)'(kpsum_pkg::REG_RANK)) begin
        rank_r <= pwdata[RW-1:0];
      end
      if (state_r == kpsum_pkg::S_EMIT && emit_go) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        kpsum_pkg::S_CLR: clr_addr_r <= clr_addr_r + VAW'(1);
        kpsum_pkg::S_IDLE: begin
          if (in_take) begin
            if (in_ch.last_element) cnt_r <= '0;
            else if (!in_full) cnt_r <= cnt_r + CW'(1);
          end
        end
        kpsum_pkg::S_CHECK: begin
          pops_r  <= rank_r;
          phase_r <= kpsum_pkg::PH_DONE;
        end
        kpsum_pkg::S_VIS: if (!vis_q) log_cnt_r <= log_cnt_r + LCW'(1);
        kpsum_pkg::S_NEXT: begin
          case (phase_r)
            kpsum_pkg::PH_UP:   phase_r <= kpsum_pkg::PH_LEFT;
            kpsum_pkg::PH_LEFT: phase_r <= kpsum_pkg::PH_DONE;
            default: ;
          endcase
        end
        kpsum_pkg::S_POP: begin
          pops_r  <= pops_r - RW'(1);
          phase_r <= kpsum_pkg::PH_UP;
        end
        kpsum_pkg::S_WIPE: begin
          if (log_cnt_r != '0) log_cnt_r <= log_m1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      kpsum_pkg::S_IDLE: begin
        if (in_take && in_ch.last_element) n_r <= in_full ? cnt_r : cnt_r + CW'(1);
      end
      kpsum_pkg::S_CHECK: begin
        err_r   <= bad_rank;
        tgt_i_r <= n_m1[IW-1:0];
        tgt_j_r <= n_m1[IW-1:0];
      end
      kpsum_pkg::S_VIS: sum_r <= {a_q[VB-1], a_q} + {b_q[VB-1], b_q};
      kpsum_pkg::S_NEXT: begin
        case (phase_r)
          kpsum_pkg::PH_UP: begin
            tgt_i_r <= pop_i_r - IW'(1);
            tgt_j_r <= pop_j_r;
          end
          kpsum_pkg::PH_LEFT: begin
            tgt_i_r <= pop_i_r;
            tgt_j_r <= pop_j_r - IW'(1);
          end
          default: ;
        endcase
      end
      kpsum_pkg::S_POP: begin
        ans_r   <= {~head_key[KW-1], head_key[KW-2:VAW]};
        pop_i_r <= head_key[VAW-1:IW];
        pop_j_r <= head_key[IW-1:0];
      end
      kpsum_pkg::S_EMIT: begin
        if (emit_go) begin
          out_sum_r    <= err_r ? '0 : ans_r;
          out_status_r <= err_r ? kpsum_pkg::STATUS_ERR : kpsum_pkg::STATUS_OK;
        end
      end
      default: ;
    endcase
  end

  // element memories
  always_ff @(posedge clk) begin
    if (state_r == kpsum_pkg::S_IDLE && in_take && !in_full) begin
      a_mem[cnt_r[IW-1:0]] <= in_ch.a_element;
      b_mem[cnt_r[IW-1:0]] <= in_ch.b_element;
    end
    a_q <= a_mem[tgt_i_r];
    b_q <= b_mem[tgt_j_r];
  end

  // visited map: swept after reset, marked on push, wiped from the log after each job
  always_ff @(posedge clk) begin
    if (state_r == kpsum_pkg::S_CLR) begin
      vis_mem[clr_addr_r] <= 1'b0;
    end else if (wipe_pend_r) begin
      vis_mem[log_q] <= 1'b0;
    end else if (state_r == kpsum_pkg::S_VIS && !vis_q) begin
      vis_mem[{tgt_i_r, tgt_j_r}] <= 1'b1;
    end
    vis_q <= vis_mem[{tgt_i_r, tgt_j_r}];
  end

  always_ff @(posedge clk) begin
    if (state_r == kpsum_pkg::S_VIS && !vis_q) begin
      log_mem[log_cnt_r[LAW-1:0]] <= {tgt_i_r, tgt_j_r};
    end
    log_q <= log_mem[log_m1[LAW-1:0]];
  end

endmodule

### hdl/kpsum_checker.sv
module kpsum_checker #(
  parameter int VALUE_BITS = 32
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_last,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [VALUE_BITS:0]             out_kth_sum,
  input logic                            out_status,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [kpsum_pkg::APB_AW-1:0]    paddr,
  input logic [kpsum_pkg::APB_DW-1:0]    pwdata,
  input logic [kpsum_pkg::APB_DW-1:0]    prdata
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kth_sum) && $stable(out_status))
    else $error("result changed while stalled");

  // the final pair of a job starts a selection that takes no items
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("item taken right after final pair");

  // an error result carries a zero sum
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == kpsum_pkg::STATUS_ERR |-> out_kth_sum == '0)
    else $error("error result with nonzero sum");

  // rank register reads back what was written
  a_rank_rb: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && !paddr[2] |=>
      paddr[2] || prdata[kpsum_pkg::RANK_W-1:0] == $past(pwdata[kpsum_pkg::RANK_W-1:0]))
    else $error("rank readback mismatch");

endmodule

bind kth_largest_pair_sum kpsum_checker #(.VALUE_BITS(VALUE_BITS)) u_kpsum_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_last     (in_ch.last_element),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_kth_sum (out_ch.kth_sum),
  .out_status  (out_ch.status),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata)
);
